// File: rtl/piaw_pkg.sv
// Shared types, constants, microcode table and arithmetic helpers of the PI controller.
package piaw_pkg;

    localparam int VALUE_WIDTH     = 32;
    localparam int TIME_WIDTH      = 48;
    localparam int STEP_WIDTH      = 32;
    localparam int FRAC_BITS       = 16;
    localparam int MUL_WIDTH       = VALUE_WIDTH + 1;
    localparam int PROD_WIDTH      = 2 * VALUE_WIDTH;
    localparam int RND_WIDTH       = PROD_WIDTH - FRAC_BITS;
    localparam int WIDE_WIDTH      = RND_WIDTH + 1;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int PC_WIDTH        = 4;

    localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic signed [PROD_WIDTH-1:0]  HALF_LSB  = PROD_WIDTH'(1) <<< (FRAC_BITS - 1);

    localparam logic signed [VALUE_WIDTH-1:0] PROP_GAIN_RST     = 32'sd65536;
    localparam logic signed [VALUE_WIDTH-1:0] INTEGRAL_GAIN_RST = 32'sd65536;
    localparam logic signed [VALUE_WIDTH-1:0] OUT_MAX_RST       = 32'sd6553600;
    localparam logic signed [VALUE_WIDTH-1:0] OUT_MIN_RST       = -32'sd6553600;
    localparam logic [STEP_WIDTH-1:0]         MAX_STEP_RST      = 32'd655360;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_TRACK = 2'd2,
        MODE_HOLD  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        LIM_NONE = 2'd0,
        LIM_HIGH = 2'd1,
        LIM_LOW  = 2'd2
    } limit_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_PROP_GAIN     = 3'd0,
        REG_INTEGRAL_GAIN = 3'd1,
        REG_OUT_MAX       = 3'd2,
        REG_OUT_MIN       = 3'd3,
        REG_MAX_STEP      = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_BUSY = 1'b1
    } state_t;

    // Operand pairing of the shared multiplier.
    typedef enum logic [1:0] {
        MUL_NONE   = 2'd0,
        MUL_PG_ERR = 2'd1,
        MUL_ERR_DT = 2'd2,
        MUL_IG_NYI = 2'd3
    } mul_sel_t;

    typedef enum logic [3:0] {
        ACT_NONE   = 4'd0,
        ACT_ERR_DT = 4'd1,
        ACT_PROP   = 4'd2,
        ACT_STEP   = 4'd3,
        ACT_NYI    = 4'd4,
        ACT_CLAMP  = 4'd5,
        ACT_HOLD   = 4'd6,
        ACT_TRACK  = 4'd7,
        ACT_OFF    = 4'd8,
        ACT_FAULT  = 4'd9
    } act_t;

    typedef enum logic [1:0] {
        JMP_NEXT       = 2'd0,
        JMP_IF_OFF     = 2'd1,
        JMP_IF_FAULT   = 2'd2,
        JMP_HOLD_TRACK = 2'd3
    } jmp_t;

    typedef struct packed {
        act_t                act;
        mul_sel_t            mul;
        jmp_t                jmp;
        logic [PC_WIDTH-1:0] target;
        logic                last;
    } ctl_word_t;

    localparam logic [PC_WIDTH-1:0] PC_ENTRY = 4'd0;
    localparam logic [PC_WIDTH-1:0] PC_GATE  = 4'd1;
    localparam logic [PC_WIDTH-1:0] PC_PROP  = 4'd2;
    localparam logic [PC_WIDTH-1:0] PC_STEP  = 4'd3;
    localparam logic [PC_WIDTH-1:0] PC_NYI   = 4'd4;
    localparam logic [PC_WIDTH-1:0] PC_TERM  = 4'd5;
    localparam logic [PC_WIDTH-1:0] PC_CLAMP = 4'd6;
    localparam logic [PC_WIDTH-1:0] PC_HOLD  = 4'd7;
    localparam logic [PC_WIDTH-1:0] PC_TRACK = 4'd8;
    localparam logic [PC_WIDTH-1:0] PC_OFF   = 4'd9;
    localparam logic [PC_WIDTH-1:0] PC_FAULT = 4'd10;

    // Control store. The hold/track dispatch goes to target for hold and target+1 for track,
    // so PC_TRACK must directly follow PC_HOLD.
    function automatic ctl_word_t ucode(input logic [PC_WIDTH-1:0] pc);
        ctl_word_t w;
        w = '{act: ACT_NONE, mul: MUL_NONE, jmp: JMP_NEXT, target: PC_ENTRY, last: 1'b1};
        unique case (pc)
            PC_ENTRY: w = '{act: ACT_ERR_DT, mul: MUL_NONE,   jmp: JMP_IF_OFF,
                            target: PC_OFF,   last: 1'b0};
            PC_GATE:  w = '{act: ACT_NONE,   mul: MUL_PG_ERR, jmp: JMP_IF_FAULT,
                            target: PC_FAULT, last: 1'b0};
            PC_PROP:  w = '{act: ACT_PROP,   mul: MUL_ERR_DT, jmp: JMP_HOLD_TRACK,
                            target: PC_HOLD,  last: 1'b0};
            PC_STEP:  w = '{act: ACT_STEP,   mul: MUL_NONE,   jmp: JMP_NEXT,
                            target: PC_ENTRY, last: 1'b0};
            PC_NYI:   w = '{act: ACT_NYI,    mul: MUL_NONE,   jmp: JMP_NEXT,
                            target: PC_ENTRY, last: 1'b0};
            PC_TERM:  w = '{act: ACT_NONE,   mul: MUL_IG_NYI, jmp: JMP_NEXT,
                            target: PC_ENTRY, last: 1'b0};
            PC_CLAMP: w = '{act: ACT_CLAMP,  mul: MUL_NONE,   jmp: JMP_NEXT,
                            target: PC_ENTRY, last: 1'b1};
            PC_HOLD:  w = '{act: ACT_HOLD,   mul: MUL_NONE,   jmp: JMP_NEXT,
                            target: PC_ENTRY, last: 1'b1};
            PC_TRACK: w = '{act: ACT_TRACK,  mul: MUL_NONE,   jmp: JMP_NEXT,
                            target: PC_ENTRY, last: 1'b1};
            PC_OFF:   w = '{act: ACT_OFF,    mul: MUL_NONE,   jmp: JMP_NEXT,
                            target: PC_ENTRY, last: 1'b1};
            PC_FAULT: w = '{act: ACT_FAULT,  mul: MUL_NONE,   jmp: JMP_NEXT,
                            target: PC_ENTRY, last: 1'b1};
            default:  w = '{act: ACT_NONE,   mul: MUL_NONE,   jmp: JMP_NEXT,
                            target: PC_ENTRY, last: 1'b1};
        endcase
        return w;
    endfunction

    // Clip a wide signed value to the signed value range.
    function automatic logic signed [VALUE_WIDTH-1:0] sat_value(
        input logic signed [WIDE_WIDTH-1:0] v
    );
        logic signed [VALUE_WIDTH-1:0] r;
        if (v > WIDE_WIDTH'(VALUE_MAX)) begin
            r = VALUE_MAX;
        end else if (v < WIDE_WIDTH'(VALUE_MIN)) begin
            r = VALUE_MIN;
        end else begin
            r = v[VALUE_WIDTH-1:0];
        end
        return r;
    endfunction

    // Round half up and drop the fraction bits of a product.
    function automatic logic signed [RND_WIDTH-1:0] round_q(
        input logic signed [PROD_WIDTH-1:0] p
    );
        logic signed [PROD_WIDTH-1:0] s;
        s = p + HALF_LSB;
        return s[PROD_WIDTH-1:FRAC_BITS];
    endfunction

endpackage

// File: rtl/pi_controller_modes_antiwindup.sv
// PI controller with off, run, track and hold modes and clamping anti-windup.
//
// One input word is one controller call; it gives exactly one result word. A small
// microprogram drives a datapath built around one shared 33x33 multiplier whose product is
// registered, and the three dependent products of a run call (P gain times error, error
// times time step, integral gain times integral) go through it one after the other. A run
// call runs entry, gate, proportional, step, new integral, term and clamp; track or hold
// ends at its own step after the proportional one, a fault at the fault step after the gate,
// and a call when off or first after off at the off step after entry. A new word is taken
// while the previous result still waits at the output; the last step of the program waits
// until that result has left. Configuration writes are accepted in every cycle and belong
// in idle periods. Values are signed Q16.16; products are rounded half up and saturated.
module pi_controller_modes_antiwindup
(
    input  logic                                    clk,
    input  logic                                    rst_n,

    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [piaw_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [piaw_pkg::VALUE_WIDTH-1:0]        cfg_data,

    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [piaw_pkg::VALUE_WIDTH-1:0] setpoint,
    input  logic signed [piaw_pkg::VALUE_WIDTH-1:0] measured,
    input  logic signed [piaw_pkg::VALUE_WIDTH-1:0] track_value,
    input  logic [1:0]                              mode,
    input  logic [piaw_pkg::TIME_WIDTH-1:0]         time_now,

    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [piaw_pkg::VALUE_WIDTH-1:0] drive,
    output logic signed [piaw_pkg::VALUE_WIDTH-1:0] integral_value,
    output logic signed [piaw_pkg::VALUE_WIDTH-1:0] prop_part,
    output logic [1:0]                              limit_status,
    output logic                                    timing_fault,
    output logic [1:0]                              mode_echo
);

    localparam int VW = piaw_pkg::VALUE_WIDTH;
    localparam int TW = piaw_pkg::TIME_WIDTH;
    localparam int WW = piaw_pkg::WIDE_WIDTH;
    localparam int MW = piaw_pkg::MUL_WIDTH;

    // Configuration registers.
    logic signed [VW-1:0]                  pg_reg, pg_next;
    logic signed [VW-1:0]                  ig_reg, ig_next;
    logic signed [VW-1:0]                  omax_reg, omax_next;
    logic signed [VW-1:0]                  omin_reg, omin_next;
    logic [piaw_pkg::STEP_WIDTH-1:0]       max_step_reg, max_step_next;

    // Controller state.
    logic [TW-1:0]                         last_time_reg, last_time_next;
    logic signed [VW-1:0]                  yi_reg, yi_next;
    logic signed [VW-1:0]                  y_reg, y_next;
    logic signed [VW-1:0]                  yp_reg, yp_next;
    piaw_pkg::mode_t                       prev_mode_reg, prev_mode_next;

    // Sequencer.
    piaw_pkg::state_t                      state_reg, state_next;
    logic [piaw_pkg::PC_WIDTH-1:0]         upc_reg, upc_next;
    piaw_pkg::ctl_word_t                   ctl;
    logic                                  go;
    logic                                  take_branch;

    // Latched call and scratch registers.
    logic signed [VW-1:0]                  sp_reg, sp_next;
    logic signed [VW-1:0]                  ms_reg, ms_next;
    logic signed [VW-1:0]                  tv_reg, tv_next;
    piaw_pkg::mode_t                       mode_reg, mode_next;
    logic [TW-1:0]                         now_reg, now_next;
    logic signed [VW-1:0]                  err_reg, err_next;
    logic [TW-1:0]                         dt_reg, dt_next;
    logic signed [VW-1:0]                  step_reg, step_next;
    logic signed [VW-1:0]                  nyi_reg, nyi_next;
    logic signed [piaw_pkg::PROD_WIDTH-1:0] prod_reg, prod_next;

    // Output word.
    logic                                  out_valid_reg, out_valid_next;
    logic signed [VW-1:0]                  o_drive_reg, o_drive_next;
    logic signed [VW-1:0]                  o_integral_reg, o_integral_next;
    logic signed [VW-1:0]                  o_prop_reg, o_prop_next;
    piaw_pkg::limit_t                      o_limit_reg, o_limit_next;
    logic                                  o_fault_reg, o_fault_next;
    piaw_pkg::mode_t                       o_mode_reg, o_mode_next;

    // Datapath signals.
    logic signed [MW-1:0]                  mul_a;
    logic signed [MW-1:0]                  mul_b;
    logic signed [2*MW-1:0]                prod_full;
    logic signed [piaw_pkg::RND_WIDTH-1:0] rnd;
    logic signed [WW-1:0]                  sum;
    piaw_pkg::limit_t                      limit_cur;
    logic                                  fault_cur;

    assign cfg_ready      = 1'b1;
    assign in_ready       = (state_reg == piaw_pkg::ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign drive          = o_drive_reg;
    assign integral_value = o_integral_reg;
    assign prop_part      = o_prop_reg;
    assign limit_status   = o_limit_reg;
    assign timing_fault   = o_fault_reg;
    assign mode_echo      = o_mode_reg;

    assign ctl = piaw_pkg::ucode(upc_reg);
    // The closing step also loads the output word, so it waits until that is free.
    assign go  = (state_reg == piaw_pkg::ST_BUSY)
                 && (!ctl.last || !out_valid_reg || out_ready);

    always_comb
    begin
        take_branch = 1'b0;
        case (ctl.jmp)
            piaw_pkg::JMP_IF_OFF:
                take_branch = (prev_mode_reg == piaw_pkg::MODE_OFF)
                              || (mode_reg == piaw_pkg::MODE_OFF);
            piaw_pkg::JMP_IF_FAULT:
                take_branch = (dt_reg > TW'(max_step_reg));
            piaw_pkg::JMP_HOLD_TRACK:
                take_branch = (mode_reg == piaw_pkg::MODE_HOLD)
                              || (mode_reg == piaw_pkg::MODE_TRACK);
            default:
                take_branch = 1'b0;
        endcase
    end

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= piaw_pkg::ST_IDLE;
            upc_reg   <= piaw_pkg::PC_ENTRY;
        end
        else
        begin
            state_reg <= state_next;
            upc_reg   <= upc_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        upc_next   = upc_reg;
        unique case (state_reg)
            piaw_pkg::ST_IDLE:
            begin
                upc_next = piaw_pkg::PC_ENTRY;
                if (in_valid)
                begin
                    state_next = piaw_pkg::ST_BUSY;
                end
            end
            piaw_pkg::ST_BUSY:
            begin
                if (go)
                begin
                    if (ctl.last)
                    begin
                        state_next = piaw_pkg::ST_IDLE;
                        upc_next   = piaw_pkg::PC_ENTRY;
                    end
                    else if (take_branch)
                    begin
                        if ((ctl.jmp == piaw_pkg::JMP_HOLD_TRACK)
                            && (mode_reg == piaw_pkg::MODE_TRACK))
                        begin
                            upc_next = ctl.target + piaw_pkg::PC_WIDTH'(1);
                        end
                        else
                        begin
                            upc_next = ctl.target;
                        end
                    end
                    else
                    begin
                        upc_next = upc_reg + piaw_pkg::PC_WIDTH'(1);
                    end
                end
            end
            default:
            begin
                state_next = piaw_pkg::ST_IDLE;
                upc_next   = piaw_pkg::PC_ENTRY;
            end
        endcase
    end

    // Shared multiplier operands.
    always_comb
    begin
        mul_a = MW'(pg_reg);
        mul_b = MW'(err_reg);
        case (ctl.mul)
            piaw_pkg::MUL_ERR_DT:
            begin
                mul_a = MW'(err_reg);
                mul_b = $signed({1'b0, dt_reg[piaw_pkg::STEP_WIDTH-1:0]});
            end
            piaw_pkg::MUL_IG_NYI:
            begin
                mul_a = MW'(ig_reg);
                mul_b = MW'(nyi_reg);
            end
            default:
            begin
                mul_a = MW'(pg_reg);
                mul_b = MW'(err_reg);
            end
        endcase
    end

    assign prod_full = mul_a * mul_b;
    assign rnd       = piaw_pkg::round_q(prod_reg);
    assign sum       = WW'(yp_reg) + WW'(rnd);

    // Datapath next values.
    always_comb
    begin
        pg_next         = pg_reg;
        ig_next         = ig_reg;
        omax_next       = omax_reg;
        omin_next       = omin_reg;
        max_step_next   = max_step_reg;
        last_time_next  = last_time_reg;
        yi_next         = yi_reg;
        y_next          = y_reg;
        yp_next         = yp_reg;
        prev_mode_next  = prev_mode_reg;
        sp_next         = sp_reg;
        ms_next         = ms_reg;
        tv_next         = tv_reg;
        mode_next       = mode_reg;
        now_next        = now_reg;
        err_next        = err_reg;
        dt_next         = dt_reg;
        step_next       = step_reg;
        nyi_next        = nyi_reg;
        prod_next       = prod_reg;
        out_valid_next  = out_valid_reg;
        o_drive_next    = o_drive_reg;
        o_integral_next = o_integral_reg;
        o_prop_next     = o_prop_reg;
        o_limit_next    = o_limit_reg;
        o_fault_next    = o_fault_reg;
        o_mode_next     = o_mode_reg;
        limit_cur       = piaw_pkg::LIM_NONE;
        fault_cur       = 1'b0;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                piaw_pkg::REG_PROP_GAIN:     pg_next       = $signed(cfg_data);
                piaw_pkg::REG_INTEGRAL_GAIN: ig_next       = $signed(cfg_data);
                piaw_pkg::REG_OUT_MAX:       omax_next     = $signed(cfg_data);
                piaw_pkg::REG_OUT_MIN:       omin_next     = $signed(cfg_data);
                piaw_pkg::REG_MAX_STEP:      max_step_next = cfg_data;
                default:                     pg_next       = pg_reg;
            endcase
        end

        if (in_valid && in_ready)
        begin
            sp_next   = setpoint;
            ms_next   = measured;
            tv_next   = track_value;
            mode_next = piaw_pkg::mode_t'(mode);
            now_next  = time_now;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (go)
        begin
            case (ctl.act)
                piaw_pkg::ACT_ERR_DT:
                begin
                    err_next = piaw_pkg::sat_value(WW'(sp_reg) - WW'(ms_reg));
                    // The time difference wraps, so a stamp going backwards is a huge step.
                    dt_next  = now_reg - last_time_reg;
                end
                piaw_pkg::ACT_PROP:
                    yp_next = piaw_pkg::sat_value(WW'(rnd));
                piaw_pkg::ACT_STEP:
                    step_next = piaw_pkg::sat_value(WW'(rnd));
                piaw_pkg::ACT_NYI:
                    nyi_next = piaw_pkg::sat_value(WW'(yi_reg) + WW'(step_reg));
                piaw_pkg::ACT_CLAMP:
                begin
                    // Within the limits the integration step is always kept; at a limit the clamp keeps it only
                    // when it pulls the integral back toward zero from the opposite sign.
                    if (sum > WW'(omax_reg))
                    begin
                        limit_cur = piaw_pkg::LIM_HIGH;
                        y_next    = omax_reg;
                        if (nyi_reg < 0 && step_reg > 0)
                        begin
                            yi_next = nyi_reg;
                        end
                    end
                    else if (sum < WW'(omin_reg))
                    begin
                        limit_cur = piaw_pkg::LIM_LOW;
                        y_next    = omin_reg;
                        if (nyi_reg > 0 && step_reg < 0)
                        begin
                            yi_next = nyi_reg;
                        end
                    end
                    else
                    begin
                        yi_next = nyi_reg;
                        y_next  = sum[VW-1:0];
                    end
                end
                piaw_pkg::ACT_HOLD:
                    yi_next = piaw_pkg::sat_value(WW'(y_reg) - WW'(yp_reg));
                piaw_pkg::ACT_TRACK:
                begin
                    yi_next = piaw_pkg::sat_value(WW'(tv_reg) - WW'(yp_reg));
                    y_next  = tv_reg;
                end
                piaw_pkg::ACT_OFF:
                begin
                    yi_next = '0;
                    y_next  = tv_reg;
                end
                piaw_pkg::ACT_FAULT:
                    fault_cur = 1'b1;
                default:
                    fault_cur = 1'b0;
            endcase

            if (ctl.mul != piaw_pkg::MUL_NONE)
            begin
                prod_next = prod_full[piaw_pkg::PROD_WIDTH-1:0];
            end

            if (ctl.last)
            begin
                last_time_next  = now_reg;
                prev_mode_next  = mode_reg;
                out_valid_next  = 1'b1;
                o_drive_next    = y_next;
                o_integral_next = yi_next;
                o_prop_next     = yp_next;
                o_limit_next    = limit_cur;
                o_fault_next    = fault_cur;
                o_mode_next     = mode_reg;
            end
        end
    end

    // Configuration, controller state and output handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pg_reg        <= piaw_pkg::PROP_GAIN_RST;
            ig_reg        <= piaw_pkg::INTEGRAL_GAIN_RST;
            omax_reg      <= piaw_pkg::OUT_MAX_RST;
            omin_reg      <= piaw_pkg::OUT_MIN_RST;
            max_step_reg  <= piaw_pkg::MAX_STEP_RST;
            last_time_reg <= '0;
            yi_reg        <= '0;
            y_reg         <= '0;
            yp_reg        <= '0;
            prev_mode_reg <= piaw_pkg::MODE_OFF;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pg_reg        <= pg_next;
            ig_reg        <= ig_next;
            omax_reg      <= omax_next;
            omin_reg      <= omin_next;
            max_step_reg  <= max_step_next;
            last_time_reg <= last_time_next;
            yi_reg        <= yi_next;
            y_reg         <= y_next;
            yp_reg        <= yp_next;
            prev_mode_reg <= prev_mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and scratch registers.
    always_ff @(posedge clk)
    begin
        sp_reg         <= sp_next;
        ms_reg         <= ms_next;
        tv_reg         <= tv_next;
        mode_reg       <= mode_next;
        now_reg        <= now_next;
        err_reg        <= err_next;
        dt_reg         <= dt_next;
        step_reg       <= step_next;
        nyi_reg        <= nyi_next;
        prod_reg       <= prod_next;
        o_drive_reg    <= o_drive_next;
        o_integral_reg <= o_integral_next;
        o_prop_reg     <= o_prop_next;
        o_limit_reg    <= o_limit_next;
        o_fault_reg    <= o_fault_next;
        o_mode_reg     <= o_mode_next;
    end

`ifndef SYNTHESIS
    a_idle_pc: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == piaw_pkg::ST_IDLE |-> upc_reg == piaw_pkg::PC_ENTRY)
        else $error("sequencer idle away from the entry step");

    a_busy_pc: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == piaw_pkg::ST_BUSY |-> upc_reg <= piaw_pkg::PC_FAULT)
        else $error("step counter outside the program");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == piaw_pkg::ST_BUSY && upc_reg == piaw_pkg::PC_ENTRY)
        else $error("accepted word did not start the program");

    a_fault_no_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && timing_fault |-> limit_status == piaw_pkg::LIM_NONE)
        else $error("timing fault reported together with a clamp");

    a_off_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mode_echo == piaw_pkg::MODE_OFF |-> integral_value == '0 && !timing_fault)
        else $error("off call left a nonzero integral or a fault");
`endif

endmodule
